// ===== src/trm_pkg.sv =====
package trm_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 15;
  localparam int ANGLE_FIELD_W = 16;
  localparam int FIELD_W       = 16;

  localparam int QBITS        = 30;
  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int X_W          = 31;  // pi/2 in Q30
  localparam int X2_W         = 32;  // (pi/2)^2 in Q30
  localparam logic [X_W-1:0] HALF_PI_Q = 31'd1686629713;

  // Horner divisors, done as reciprocal multiply plus one correction step.
  localparam int HORNER_STEPS = 5;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned HORNER_SHIFT [HORNER_STEPS] = '{38, 38, 37, 36, 34};
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'((64'd1 << 38) / 110),
    32'((64'd1 << 38) / 72),
    32'((64'd1 << 37) / 42),
    32'((64'd1 << 36) / 20),
    32'((64'd1 << 34) / 6)
  };

  localparam int SINE_W    = FRACTION_BITS + 1;
  localparam int SINE_LAT  = 2 + 4 * HORNER_STEPS + 2;
  localparam int MAT_LAT   = 4;
  localparam int BACK_LAT  = SINE_LAT + MAT_LAT;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [SINE_W-1:0] sine_t;

  typedef struct packed {
    logic                  neg;
    logic [QUARTER_BITS:0] r;
  } sine_req_t;

  typedef struct packed {
    sine_req_t sa;
    sine_req_t ca;
    sine_req_t sd;
    sine_req_t cd;
    sine_req_t sz;
    sine_req_t cz;
  } trm_req_t;

endpackage

// ===== src/trm_if.sv =====
interface trm_in_if;
  logic                               valid;
  logic                               ready;
  logic [trm_pkg::ANGLE_FIELD_W-1:0]  angle_alpha;
  logic [trm_pkg::ANGLE_FIELD_W-1:0]  angle_delta;
  logic [trm_pkg::ANGLE_FIELD_W-1:0]  angle_azimuth;

  modport source (output valid, angle_alpha, angle_delta, angle_azimuth, input ready);
  modport sink (input valid, angle_alpha, angle_delta, angle_azimuth, output ready);
endinterface

interface trm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [trm_pkg::FIELD_W-1:0]  row0_col0;
  logic signed [trm_pkg::FIELD_W-1:0]  row0_col1;
  logic signed [trm_pkg::FIELD_W-1:0]  row0_col2;
  logic signed [trm_pkg::FIELD_W-1:0]  row1_col0;
  logic signed [trm_pkg::FIELD_W-1:0]  row1_col1;
  logic signed [trm_pkg::FIELD_W-1:0]  row1_col2;
  logic signed [trm_pkg::FIELD_W-1:0]  row2_col0;
  logic signed [trm_pkg::FIELD_W-1:0]  row2_col1;
  logic signed [trm_pkg::FIELD_W-1:0]  row2_col2;

  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, input ready);
  modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                row1_col2, row2_col0, row2_col1, row2_col2, output ready);
endinterface

// ===== src/three_angle_rotation_matrix.sv =====
// Rotation matrix from three binary angles (right ascension, declination,
// azimuth; a full turn is 65536). Each word on req carries the three angles;
// each word on rsp carries the nine matrix entries, signed Q1.15.
// Both channels are valid/ready; a word moves when both are high.
// A front stage classifies each angle into quadrant and folded remainder and
// pushes a word into a 4-entry queue. The back end pops the queue into a
// 28-stage pipeline: six sine units (x, x^2, five Horner terms of 4 stages
// each with a reciprocal-multiply divide, final multiply and round) followed
// by four stages of matrix products and sums.
// Throughput is one word per cycle unless the pipeline holds; the Horner
// chain and the back pipeline each take a new word every cycle they advance.
// The whole back pipeline holds while rsp.valid is high and rsp.ready low;
// the queue and front stage keep taking words until they fill, then
// req.ready drops. Reset empties the front stage, the queue and the pipeline
// valid bits.
module three_angle_rotation_matrix (
  input  logic   clk,
  input  logic   rst,
  trm_in_if.sink    req,
  trm_out_if.source rsp
);
  logic              push, full, pop, not_empty;
  trm_pkg::trm_req_t push_word, head_word;

  trm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (push),
    .push_word (push_word),
    .full      (full)
  );

  trm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .head_word (head_word),
    .not_empty (not_empty)
  );

  trm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (not_empty),
    .fifo_word  (head_word),
    .fifo_pop   (pop),
    .rsp        (rsp)
  );
endmodule

// ===== src/trm_front.sv =====
module trm_front (
  input  logic              clk,
  input  logic              rst,
  trm_in_if.sink            req,
  output logic              push,
  output trm_pkg::trm_req_t push_word,
  input  logic              full
);
  localparam int AB = trm_pkg::ANGLE_BITS;
  localparam int QB = trm_pkg::QUARTER_BITS;
  localparam logic [AB-1:0] QUARTER_A = AB'(1) << QB;
  localparam logic [QB:0]   QUARTER_R = (QB + 1)'(1) << QB;

  logic              fv;
  trm_pkg::trm_req_t fword;

  // quadrant split: odd quadrants mirror the remainder, upper half negates
  function automatic trm_pkg::sine_req_t classify(input logic [AB-1:0] a);
    trm_pkg::sine_req_t o;
    o.neg = a[AB-1];
    o.r   = a[AB-2] ? QUARTER_R - {1'b0, a[QB-1:0]} : {1'b0, a[QB-1:0]};
    return o;
  endfunction

  logic [AB-1:0] al, de, az;
  assign al = AB'(req.angle_alpha);
  assign de = AB'(req.angle_delta);
  assign az = AB'(req.angle_azimuth);

  assign req.ready = !fv || !full;
  assign push      = fv && !full;
  assign push_word = fword;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (req.valid && req.ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      fword.sa <= classify(al);
      fword.ca <= classify(al + QUARTER_A);
      fword.sd <= classify(de);
      fword.cd <= classify(de + QUARTER_A);
      fword.sz <= classify(az);
      fword.cz <= classify(az + QUARTER_A);
    end
  end
endmodule

// ===== src/trm_fifo.sv =====
module trm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trm_pkg::trm_req_t push_word,
  output logic              full,
  input  logic              pop,
  output trm_pkg::trm_req_t head_word,
  output logic              not_empty
);
  localparam int DEPTH = trm_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  trm_pkg::trm_req_t mem [DEPTH];
  logic [PW-1:0]     wp, rp;
  logic [PW:0]       cnt;

  assign full      = (cnt == (PW + 1)'(DEPTH));
  assign not_empty = (cnt != '0);
  assign head_word = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_word;
    end
  end
endmodule

// ===== src/trm_sine.sv =====
module trm_sine (
  input  logic               clk,
  input  logic               en,
  input  trm_pkg::sine_req_t req,
  output trm_pkg::sine_t     sine
);
  localparam int QB  = trm_pkg::QUARTER_BITS;
  localparam int QW  = trm_pkg::QBITS;
  localparam int FB  = trm_pkg::FRACTION_BITS;
  localparam int SW  = trm_pkg::SINE_W;
  localparam int XW  = trm_pkg::X_W;
  localparam int X2W = trm_pkg::X2_W;
  localparam int TW  = QW + 1;
  localparam int NH  = trm_pkg::HORNER_STEPS;
  localparam int LAT = trm_pkg::SINE_LAT;
  localparam int RS  = QW - FB;
  localparam int PMW = X2W + 32;
  localparam logic [TW-1:0] Q_ONE    = TW'(1) << QW;
  localparam logic [XW:0]   RND_HALF = (XW + 1)'(1) << (RS - 1);
  localparam logic [XW:0]   MAG_MAX  = ((XW + 1)'(1) << FB) - 1'b1;

  logic [XW-1:0]  x_d   [LAT-2];
  logic [X2W-1:0] x2_d  [4*(NH-1)+1];
  logic           neg_d [LAT-1];
  logic [TW-1:0]  t     [NH];
  logic [XW-1:0]  s;

  logic [QB+XW:0]    xp;
  logic [2*XW-1:0]   x_sq;
  logic [XW+TW-1:0]  xt;
  logic [XW:0]       sum_r, m, mag;
  logic [SW-1:0]     magn;
  trm_pkg::sine_t    sine_next;

  assign xp   = (QB + XW + 1)'(req.r) * (QB + XW + 1)'(trm_pkg::HALF_PI_Q);
  assign x_sq = (2 * XW)'(x_d[0]) * (2 * XW)'(x_d[0]);
  assign xt   = (XW + TW)'(x_d[LAT-3]) * (XW + TW)'(t[NH-1]);

  always_comb begin
    sum_r     = (XW + 1)'(s) + RND_HALF;
    m         = sum_r >> RS;
    mag       = (m > MAG_MAX) ? MAG_MAX : m;
    magn      = mag[SW-1:0];
    sine_next = neg_d[LAT-2] ? trm_pkg::sine_t'(-magn) : trm_pkg::sine_t'(magn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_d[0]   <= xp[QB +: XW];
      neg_d[0] <= req.neg;
      x2_d[0]  <= X2W'(x_sq >> QW);
      for (int k = 1; k < LAT - 2; k++) begin
        x_d[k] <= x_d[k-1];
      end
      for (int k = 1; k < LAT - 1; k++) begin
        neg_d[k] <= neg_d[k-1];
      end
      for (int k = 1; k < 4 * (NH - 1) + 1; k++) begin
        x2_d[k] <= x2_d[k-1];
      end
      s    <= XW'(xt >> QW);
      sine <= sine_next;
    end
  end

  // t = 1 - x^2 * t / k, four stages per term
  for (genvar h = 0; h < NH; h++) begin : g_horner
    localparam logic [X2W-1:0] K     = X2W'(trm_pkg::HORNER_DIV[h]);
    localparam int             SH    = trm_pkg::HORNER_SHIFT[h];
    localparam logic [31:0]    RECIP = trm_pkg::HORNER_RECIP[h];

    logic [TW-1:0]      t_in;
    logic [X2W+TW-1:0]  pa;
    logic [X2W-1:0]     v, vb, vc, q0, qk, qs, rem, u;
    logic [PMW-1:0]     pm;
    logic [TW-1:0]      t_next;

    if (h == 0) begin : g_first
      assign t_in = Q_ONE;
    end else begin : g_rest
      assign t_in = t[h-1];
    end

    assign pa = (X2W + TW)'(x2_d[4*h]) * (X2W + TW)'(t_in);
    assign qs = X2W'(pm >> SH);

    always_comb begin
      rem    = vc - qk;
      u      = (rem >= K) ? q0 + 1'b1 : q0;
      t_next = (u >= X2W'(Q_ONE)) ? '0 : Q_ONE - TW'(u);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v    <= X2W'(pa >> QW);
        pm   <= PMW'(v) * PMW'(RECIP);
        vb   <= v;
        q0   <= qs;
        qk   <= X2W'(qs * K);
        vc   <= vb;
        t[h] <= t_next;
      end
    end
  end
endmodule

// ===== src/trm_back.sv =====
module trm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              fifo_valid,
  input  trm_pkg::trm_req_t fifo_word,
  output logic              fifo_pop,
  trm_out_if.source         rsp
);
  localparam int SW   = trm_pkg::SINE_W;
  localparam int FB   = trm_pkg::FRACTION_BITS;
  localparam int PW   = 2 * SW;
  localparam int SUMW = SW + 2;
  localparam int FW   = trm_pkg::FIELD_W;
  localparam int LAT  = trm_pkg::BACK_LAT;
  localparam logic [PW-1:0] HALF_LSB = PW'(1) << (FB - 1);
  localparam logic signed [SUMW-1:0] FX_MAX = (SUMW'(1) << FB) - 1'b1;
  localparam logic signed [SUMW-1:0] FX_MIN = -(SUMW'(1) << FB);

  logic           adv;
  logic [LAT-1:0] vld;

  trm_pkg::sine_t sa, ca, sd, cd, sz, cz;

  // product rounded to nearest, halves away from zero
  function automatic trm_pkg::sine_t fx_round(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] rnd;
    logic [SW-1:0] mag;
    m   = p[PW-1] ? (~p + 1'b1) : p;
    rnd = (m + HALF_LSB) >> FB;
    mag = rnd[SW-1:0];
    return p[PW-1] ? trm_pkg::sine_t'(-mag) : trm_pkg::sine_t'(mag);
  endfunction

  function automatic logic [FW-1:0] to_field(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] c;
    logic signed [31:0]     w;
    c = (v > FX_MAX) ? FX_MAX : ((v < FX_MIN) ? FX_MIN : v);
    w = 32'(c);
    return w[FW-1:0];
  endfunction

  assign adv      = !vld[LAT-1] || rsp.ready;
  assign fifo_pop = adv && fifo_valid;

  trm_sine u_sa (.clk(clk), .en(adv), .req(fifo_word.sa), .sine(sa));
  trm_sine u_ca (.clk(clk), .en(adv), .req(fifo_word.ca), .sine(ca));
  trm_sine u_sd (.clk(clk), .en(adv), .req(fifo_word.sd), .sine(sd));
  trm_sine u_cd (.clk(clk), .en(adv), .req(fifo_word.cd), .sine(cd));
  trm_sine u_sz (.clk(clk), .en(adv), .req(fifo_word.sz), .sine(sz));
  trm_sine u_cz (.clk(clk), .en(adv), .req(fifo_word.cz), .sine(cz));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], fifo_valid};
    end
  end

  logic signed [PW-1:0] p_czsa, p_szca, p_czca, p_szsa, p_szcd, p_czcd, p_cacd, p_sacd;
  trm_pkg::sine_t       r_czsa, r_szca, r_czca, r_szsa, r_szcd, r_czcd, r_cacd, r_sacd;
  trm_pkg::sine_t       h_czsa, h_szca, h_czca, h_szsa, h_szcd, h_czcd, h_cacd, h_sacd;
  logic signed [PW-1:0] t_szca, t_szsa, t_czca, t_czsa;
  trm_pkg::sine_t       sd1, sd2, sd3;
  logic [FW-1:0]        f [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_czsa <= cz * sa;
      p_szca <= sz * ca;
      p_czca <= cz * ca;
      p_szsa <= sz * sa;
      p_szcd <= sz * cd;
      p_czcd <= cz * cd;
      p_cacd <= ca * cd;
      p_sacd <= sa * cd;
      sd1    <= sd;

      r_czsa <= fx_round(p_czsa);
      r_szca <= fx_round(p_szca);
      r_czca <= fx_round(p_czca);
      r_szsa <= fx_round(p_szsa);
      r_szcd <= fx_round(p_szcd);
      r_czcd <= fx_round(p_czcd);
      r_cacd <= fx_round(p_cacd);
      r_sacd <= fx_round(p_sacd);
      sd2    <= sd1;

      t_szca <= r_szca * sd2;
      t_szsa <= r_szsa * sd2;
      t_czca <= r_czca * sd2;
      t_czsa <= r_czsa * sd2;
      h_czsa <= r_czsa;
      h_szca <= r_szca;
      h_czca <= r_czca;
      h_szsa <= r_szsa;
      h_szcd <= r_szcd;
      h_czcd <= r_czcd;
      h_cacd <= r_cacd;
      h_sacd <= r_sacd;
      sd3    <= sd2;

      f[0] <= to_field(-SUMW'(h_czsa) - SUMW'(fx_round(t_szca)));
      f[1] <= to_field(SUMW'(h_czca) - SUMW'(fx_round(t_szsa)));
      f[2] <= to_field(SUMW'(h_szcd));
      f[3] <= to_field(SUMW'(h_szsa) - SUMW'(fx_round(t_czca)));
      f[4] <= to_field(-SUMW'(h_szca) - SUMW'(fx_round(t_czsa)));
      f[5] <= to_field(SUMW'(h_czcd));
      f[6] <= to_field(SUMW'(h_cacd));
      f[7] <= to_field(SUMW'(h_sacd));
      f[8] <= to_field(SUMW'(sd3));
    end
  end

  assign rsp.valid     = vld[LAT-1];
  assign rsp.row0_col0 = f[0];
  assign rsp.row0_col1 = f[1];
  assign rsp.row0_col2 = f[2];
  assign rsp.row1_col0 = f[3];
  assign rsp.row1_col1 = f[4];
  assign rsp.row1_col2 = f[5];
  assign rsp.row2_col0 = f[6];
  assign rsp.row2_col1 = f[7];
  assign rsp.row2_col2 = f[8];
endmodule
